// ----- rtl/core/mml_pkg.sv -----
// Shared types and constants of the note sequencer: parser phases, command
// characters, sequencer states and the frequency table.
// No dependencies.
`timescale 1ns / 1ps
package mml_pkg;

  typedef enum logic [2:0] {
    PH_IDLE, PH_AWAIT, PH_NUMBER, PH_MOD, PH_DOTS, PH_MCMD
  } phase_t;

  typedef enum logic [2:0] {
    K_NONE, K_LEN, K_OCT, K_TEMPO, K_NOTENUM, K_NOTELEN
  } kind_t;

  typedef enum logic [1:0] {
    ART_NORMAL, ART_LEGATO, ART_STACCATO
  } art_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_BASE, ST_ON_GO, ST_ON_WAIT, ST_OFF_GO, ST_OFF_WAIT, ST_DONE
  } seq_t;

  localparam int TABLE_ENTRIES = 97;
  localparam logic [2:0] MAX_DOTS = 3'd7;
  localparam logic [6:0] IDX_MAX = 7'(TABLE_ENTRIES - 1);
  localparam int NUM_W = 40;
  localparam int DEN_W = 24;

  // Whole-note time at tempo 1, in microseconds
  localparam logic [NUM_W-1:0] US_WHOLE = 40'd240000000;

  // Command characters (letters in lower case) and the upper-case letter range
  localparam logic [7:0] CH_EOT   = 8'h00;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SHARP = 8'h23;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;

  // Dotted-note numerator: whole-note time times 3^k
  function automatic logic [NUM_W-1:0] dot_num(input logic [2:0] k);
    logic [NUM_W-1:0] r;
    case (k)
      3'd0: r = 40'd240000000;
      3'd1: r = 40'd720000000;
      3'd2: r = 40'd2160000000;
      3'd3: r = 40'd6480000000;
      3'd4: r = 40'd19440000000;
      3'd5: r = 40'd58320000000;
      3'd6: r = 40'd174960000000;
      default: r = 40'd524880000000;
    endcase
    return r;
  endfunction

  localparam logic [11:0] FREQ_TAB [0:TABLE_ENTRIES-1] = '{
    12'd0,
    12'd16, 12'd17, 12'd18, 12'd19, 12'd20, 12'd21, 12'd23, 12'd24, 12'd25, 12'd27,
    12'd29, 12'd30,
    12'd32, 12'd34, 12'd36, 12'd38, 12'd41, 12'd43, 12'd46, 12'd49, 12'd51, 12'd55,
    12'd58, 12'd61,
    12'd65, 12'd69, 12'd73, 12'd77, 12'd82, 12'd87, 12'd92, 12'd98, 12'd103, 12'd110,
    12'd116, 12'd123,
    12'd130, 12'd138, 12'd146, 12'd155, 12'd164, 12'd174, 12'd185, 12'd196, 12'd207,
    12'd220, 12'd233, 12'd246,
    12'd261, 12'd277, 12'd293, 12'd311, 12'd329, 12'd349, 12'd370, 12'd392, 12'd415,
    12'd440, 12'd466, 12'd493,
    12'd523, 12'd554, 12'd587, 12'd622, 12'd659, 12'd698, 12'd739, 12'd783, 12'd830,
    12'd880, 12'd932, 12'd987,
    12'd1046, 12'd1108, 12'd1174, 12'd1244, 12'd1318, 12'd1396, 12'd1479, 12'd1567,
    12'd1661, 12'd1760, 12'd1864, 12'd1975,
    12'd2093, 12'd2217, 12'd2349, 12'd2489, 12'd2637, 12'd2793, 12'd2959, 12'd3135,
    12'd3322, 12'd3520, 12'd3729, 12'd3951
  };

endpackage

// ----- rtl/core/mml_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; widths come from its parameters.
`timescale 1ns / 1ps
module mml_div #(
  parameter int NW = 40,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quot
);
  localparam int CW = $clog2(NW);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;

  // Load the operands on start, else one restoring step on the shifted remainder
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[DW-1:0], q_r[NW-1]};
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;

endmodule

// ----- rtl/core/mml_note_sequencer_unit.sv -----
// Top level of the note sequencer: text parser, note sequencer and the
// shared divider. Depends on mml_pkg and mml_div.
`timescale 1ns / 1ps
// A byte that completes no note is taken and the block stays ready.
// A byte that completes a note occupies the block until its event is
// taken: length times tempo is registered, then the shared divider works out
// the sounding time and, with normal or staccato articulation and no dots,
// the gap; then the block waits for out_ready. The end-of-text byte gives a
// result with song_end set.
module mml_note_sequencer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ch,
  input  logic        in_first,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_note_index,
  output logic [11:0] out_freq_hz,
  output logic [26:0] out_on_time_us,
  output logic [20:0] out_off_time_us,
  output logic        out_has_note,
  output logic        out_song_end
);
  import mml_pkg::*;

  // Parser state
  phase_t     phase_r, phase_nxt;
  kind_t      kind_r, kind_nxt;
  art_t       art_r, art_nxt;
  logic [2:0] oct_r, oct_nxt;
  logic [6:0] dlen_r, dlen_nxt;
  logic [7:0] tempo_r, tempo_nxt;
  logic       play_r, play_nxt;
  logic [6:0] note_r, note_nxt;
  logic [2:0] dots_r, dots_nxt;
  logic [9:0] acc_r, acc_nxt;

  logic       emit, fin, do_mod, do_idle, is_dig;
  logic [7:0] c;
  logic [3:0] dig;
  logic [6:0] e_len, snap_note;
  logic [2:0] snap_oct, snap_dots;
  art_t       snap_art;
  logic [13:0] acc_mul;
  logic [7:0] idx_sum;
  logic [6:0] snap_idx;

  // Event registers
  seq_t        st_r, st_nxt;
  logic [6:0]  e_idx_r, e_len_r;
  logic [2:0]  e_dots_r;
  art_t        e_art_r;
  logic [7:0]  e_tempo_r;
  logic        e_has_r, e_end_r;
  logic [13:0] base_r;
  logic [26:0] on_r;
  logic [20:0] off_r;

  logic              div_start, div_busy, div_done;
  logic [NUM_W-1:0]  div_num, div_quot;
  logic [DEN_W-1:0]  div_den;
  logic              need_off;
  logic              accept;

  assign accept = in_valid && in_ready;

  function automatic logic [6:0] clamp_len(input logic [9:0] v);
    return (v == 10'd0) ? 7'd1 : ((v > 10'd64) ? 7'd64 : v[6:0]);
  endfunction

  // Parse one byte: next parser state and the note that completes, if any
  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    art_nxt   = art_r;
    oct_nxt   = oct_r;
    dlen_nxt  = dlen_r;
    tempo_nxt = tempo_r;
    play_nxt  = play_r;
    note_nxt  = note_r;
    dots_nxt  = dots_r;
    acc_nxt   = acc_r;
    emit      = 1'b0;
    fin       = 1'b0;
    do_mod    = 1'b0;
    do_idle   = 1'b0;
    e_len     = dlen_r;
    c         = in_ch;
    if (in_ch inside {[CH_UP_A:CH_UP_Z]}) begin
      c = in_ch | 8'h20;
    end
    is_dig  = c inside {[CH_ZERO:CH_NINE]};
    dig     = 4'(c - CH_ZERO);
    acc_mul = {1'b0, acc_r, 3'b0} + {3'b0, acc_r, 1'b0} + {10'b0, dig};

    if (in_first) begin
      phase_nxt = PH_IDLE;
      kind_nxt  = K_NONE;
      art_nxt   = ART_NORMAL;
      oct_nxt   = 3'd4;
      dlen_nxt  = 7'd4;
      tempo_nxt = 8'd120;
      play_nxt  = 1'b1;
      note_nxt  = '0;
      dots_nxt  = '0;
      acc_nxt   = '0;
      e_len     = 7'd4;
    end

    if (play_nxt) begin
      if (c == CH_EOT) begin
        // End of text: flush any pending note or number
        fin = 1'b1;
        if (phase_nxt == PH_MOD || phase_nxt == PH_DOTS ||
            (phase_nxt == PH_AWAIT && kind_nxt == K_NOTELEN)) begin
          emit = 1'b1;
        end else if (phase_nxt == PH_NUMBER) begin
          if (kind_nxt == K_NOTELEN) begin
            emit  = 1'b1;
            e_len = clamp_len(acc_nxt);
          end else if (kind_nxt == K_NOTENUM) begin
            note_nxt = (acc_nxt > 10'd96) ? 7'd96 : acc_nxt[6:0];
            dots_nxt = '0;
            emit     = 1'b1;
          end else if (kind_nxt == K_LEN) begin
            dlen_nxt = clamp_len(acc_nxt);
          end else if (kind_nxt == K_OCT) begin
            oct_nxt = (acc_nxt > 10'd7) ? 3'd7 : acc_nxt[2:0];
          end else if (kind_nxt == K_TEMPO) begin
            tempo_nxt = (acc_nxt < 10'd32) ? 8'd32 :
                        ((acc_nxt > 10'd255) ? 8'd255 : acc_nxt[7:0]);
          end
        end
        play_nxt  = 1'b0;
        phase_nxt = PH_IDLE;
        kind_nxt  = K_NONE;
      end else begin
        case (phase_nxt)
          PH_MCMD: begin
            if (c == CH_N) art_nxt = ART_NORMAL;
            else if (c == CH_L) art_nxt = ART_LEGATO;
            else if (c == CH_S) art_nxt = ART_STACCATO;
            phase_nxt = PH_IDLE;
          end
          PH_AWAIT: begin
            if (is_dig) begin
              acc_nxt   = {6'b0, dig};
              phase_nxt = PH_NUMBER;
            end else begin
              emit    = (kind_nxt == K_NOTELEN);
              do_idle = 1'b1;
            end
          end
          PH_NUMBER: begin
            if (is_dig) begin
              acc_nxt = (acc_mul > 14'd1023) ? 10'd1023 : acc_mul[9:0];
            end else if (kind_nxt == K_NOTELEN) begin
              emit    = 1'b1;
              e_len   = clamp_len(acc_nxt);
              do_idle = 1'b1;
            end else if (kind_nxt == K_NOTENUM) begin
              note_nxt  = (acc_nxt > 10'd96) ? 7'd96 : acc_nxt[6:0];
              dots_nxt  = '0;
              phase_nxt = PH_MOD;
              do_mod    = 1'b1;
            end else begin
              if (kind_nxt == K_LEN) begin
                dlen_nxt = clamp_len(acc_nxt);
              end else if (kind_nxt == K_OCT) begin
                oct_nxt = (acc_nxt > 10'd7) ? 3'd7 : acc_nxt[2:0];
              end else if (kind_nxt == K_TEMPO) begin
                tempo_nxt = (acc_nxt < 10'd32) ? 8'd32 :
                            ((acc_nxt > 10'd255) ? 8'd255 : acc_nxt[7:0]);
              end
              do_idle = 1'b1;
            end
          end
          PH_MOD: do_mod = 1'b1;
          PH_DOTS: begin
            if (c == CH_DOT) begin
              if (dots_nxt < MAX_DOTS) dots_nxt = dots_nxt + 3'd1;
            end else if (is_dig) begin
              acc_nxt   = {6'b0, dig};
              kind_nxt  = K_NOTELEN;
              phase_nxt = PH_NUMBER;
            end else begin
              emit    = 1'b1;
              do_idle = 1'b1;
            end
          end
          default: do_idle = 1'b1;
        endcase

        // Note modifier: accidental, dots, length or end of note
        if (do_mod) begin
          if (c == CH_PLUS || c == CH_SHARP) begin
            note_nxt  = note_nxt + 7'd1;
            phase_nxt = PH_AWAIT;
            kind_nxt  = K_NOTELEN;
          end else if (c == CH_MINUS) begin
            if (note_nxt != 7'd0) note_nxt = note_nxt - 7'd1;
            phase_nxt = PH_AWAIT;
            kind_nxt  = K_NOTELEN;
          end else if (c == CH_DOT) begin
            dots_nxt  = 3'd1;
            phase_nxt = PH_DOTS;
          end else if (is_dig) begin
            acc_nxt   = {6'b0, dig};
            kind_nxt  = K_NOTELEN;
            phase_nxt = PH_NUMBER;
          end else begin
            emit    = 1'b1;
            do_idle = 1'b1;
          end
        end
      end
    end

    // Snapshot the note before the byte is parsed as a new command
    snap_note = note_nxt;
    snap_oct  = oct_nxt;
    snap_dots = dots_nxt;
    snap_art  = art_nxt;

    // Parse the byte as a fresh command
    if (do_idle) begin
      phase_nxt = PH_IDLE;
      case (c)
        CH_A, CH_B, CH_C, CH_D, CH_E, CH_F, CH_G, CH_P, CH_R: begin
          case (c)
            CH_A:    note_nxt = 7'd10;
            CH_B:    note_nxt = 7'd12;
            CH_C:    note_nxt = 7'd1;
            CH_D:    note_nxt = 7'd3;
            CH_E:    note_nxt = 7'd5;
            CH_F:    note_nxt = 7'd6;
            CH_G:    note_nxt = 7'd8;
            default: note_nxt = 7'd0;
          endcase
          dots_nxt  = '0;
          phase_nxt = PH_MOD;
        end
        CH_L: begin phase_nxt = PH_AWAIT; kind_nxt = K_LEN; end
        CH_O: begin phase_nxt = PH_AWAIT; kind_nxt = K_OCT; end
        CH_T: begin phase_nxt = PH_AWAIT; kind_nxt = K_TEMPO; end
        CH_N: begin phase_nxt = PH_AWAIT; kind_nxt = K_NOTENUM; end
        CH_M: phase_nxt = PH_MCMD;
        CH_LT: if (oct_nxt != 3'd0) oct_nxt = oct_nxt - 3'd1;
        CH_GT: if (oct_nxt != 3'd7) oct_nxt = oct_nxt + 3'd1;
        default: ;
      endcase
    end

    idx_sum  = {1'b0, snap_note} + 8'({snap_oct, 3'b0} + {snap_oct, 2'b0});
    snap_idx = (snap_note == 7'd0) ? 7'd0 :
               ((idx_sum > {1'b0, IDX_MAX}) ? IDX_MAX : idx_sum[6:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      kind_r  <= K_NONE;
      art_r   <= ART_NORMAL;
      oct_r   <= 3'd4;
      dlen_r  <= 7'd4;
      tempo_r <= 8'd120;
      play_r  <= 1'b0;
      note_r  <= '0;
      dots_r  <= '0;
      acc_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      art_r   <= art_nxt;
      oct_r   <= oct_nxt;
      dlen_r  <= dlen_nxt;
      tempo_r <= tempo_nxt;
      play_r  <= play_nxt;
      note_r  <= note_nxt;
      dots_r  <= dots_nxt;
      acc_r   <= acc_nxt;
    end
  end

  // Divider operands for the sounding time and the gap
  assign need_off = (e_dots_r == 3'd0) && (e_art_r != ART_LEGATO);

  always_comb begin
    div_num = US_WHOLE;
    div_den = {10'b0, base_r};
    if (st_r == ST_ON_GO) begin
      if (e_dots_r != 3'd0) begin
        div_num = dot_num(e_dots_r);
        div_den = {10'b0, base_r} << e_dots_r;
      end else if (e_art_r == ART_STACCATO) begin
        div_num = US_WHOLE * 3;
        div_den = {10'b0, base_r} << 2;
      end else if (e_art_r == ART_NORMAL) begin
        div_num = US_WHOLE * 7;
        div_den = {10'b0, base_r} << 3;
      end
    end else if (e_art_r == ART_STACCATO) begin
      div_den = {10'b0, base_r} << 2;
    end else begin
      div_den = {10'b0, base_r} << 3;
    end
  end

  assign div_start = (st_r == ST_ON_GO) || (st_r == ST_OFF_GO);

  mml_div #(
    .NW(NUM_W),
    .DW(DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Sequencer: next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (accept && emit) st_nxt = ST_BASE;
        else if (accept && fin) st_nxt = ST_DONE;
      end
      ST_BASE:    st_nxt = ST_ON_GO;
      ST_ON_GO:   st_nxt = ST_ON_WAIT;
      ST_ON_WAIT: if (div_done) st_nxt = need_off ? ST_OFF_GO : ST_DONE;
      ST_OFF_GO:  st_nxt = ST_OFF_WAIT;
      ST_OFF_WAIT: if (div_done) st_nxt = ST_DONE;
      ST_DONE:    if (out_ready) st_nxt = ST_IDLE;
      default:    st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Event payload: load on accept, fill in as the divider finishes
  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && accept) begin
      e_idx_r   <= emit ? snap_idx : 7'd0;
      e_len_r   <= e_len;
      e_dots_r  <= snap_dots;
      e_art_r   <= snap_art;
      e_tempo_r <= tempo_nxt;
      e_has_r   <= emit;
      e_end_r   <= fin;
      on_r      <= '0;
      off_r     <= '0;
    end
    if (st_r == ST_BASE) begin
      base_r <= e_len_r * e_tempo_r;
    end
    if (st_r == ST_ON_WAIT && div_done) begin
      on_r <= div_quot[26:0];
    end
    if (st_r == ST_OFF_WAIT && div_done) begin
      off_r <= div_quot[20:0];
    end
  end

  assign in_ready        = (st_r == ST_IDLE);
  assign out_valid       = (st_r == ST_DONE);
  assign out_note_index  = e_idx_r;
  assign out_freq_hz     = FREQ_TAB[e_idx_r];
  assign out_on_time_us  = on_r;
  assign out_off_time_us = off_r;
  assign out_has_note    = e_has_r;
  assign out_song_end    = e_end_r;

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result waits");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_note) |-> out_song_end)
    else $error("result with neither note nor song end");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_note_index <= IDX_MAX))
    else $error("note index out of table");
`endif

endmodule
